// File: sv/ftprf_pkg.sv
`timescale 1ns / 1ps

package ftprf_pkg;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [3:0] DIGIT_HI  = 4'h3;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;
  localparam logic [2:0]  POS_MAX = 3'd4;
  localparam logic [2:0]  POS_SEP = 3'd3;

  // first-line separator codes
  localparam logic [1:0] SEP_NONE   = 2'd0;
  localparam logic [1:0] SEP_SPACE  = 2'd1;
  localparam logic [1:0] SEP_HYPHEN = 2'd2;
  localparam logic [1:0] SEP_OTHER  = 2'd3;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_MALFORMED = 1'b1;

  typedef struct packed {
    logic            cont;
    logic [2:0][3:0] dig;
    logic [2:0]      pos;
    logic            match;
    logic [1:0]      sep;
    logic            pcr;
    logic [15:0]     cnt;
  } frm_state_t;

  typedef struct packed {
    logic        emit;
    logic [9:0]  code;
    logic        status;
    logic [15:0] length;
  } frm_result_t;

  localparam frm_state_t STATE_RESET = '{
    cont:  1'b0,
    dig:   '0,
    pos:   3'd0,
    match: 1'b1,
    sep:   SEP_NONE,
    pcr:   1'b0,
    cnt:   16'd0
  };

endpackage

// File: sv/ftprf_if.sv
`timescale 1ns / 1ps

interface ftprf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ftprf_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  reply_code;
  logic        reply_status;
  logic [15:0] reply_length;

  modport source (output valid, output reply_code, output reply_status,
                  output reply_length, input ready);
  modport sink   (input valid, input reply_code, input reply_status,
                  input reply_length, output ready);
endinterface

// File: sv/ftprf_core.sv
`timescale 1ns / 1ps

module ftprf_core
  import ftprf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  logic [7:0]  byte_in,
  output frm_result_t res
);

  frm_state_t st_r;
  frm_state_t st_nxt;

  function automatic frm_state_t take_char(frm_state_t s, logic [7:0] c);
    frm_state_t n;
    logic       is_digit;
    n = s;
    is_digit = (c >= 8'h30) && (c <= 8'h39);
    if (!s.cont) begin
      if (s.pos < POS_SEP) begin
        if (is_digit) n.dig[s.pos[1:0]] = c[3:0];
        else n.match = 1'b0;
      end else if (s.pos == POS_SEP) begin
        if (c == CH_SPACE) n.sep = SEP_SPACE;
        else if (c == CH_HYPHEN) n.sep = SEP_HYPHEN;
        else n.sep = SEP_OTHER;
      end
    end else begin
      if (s.pos < POS_SEP) begin
        if (c != {DIGIT_HI, s.dig[s.pos[1:0]]}) n.match = 1'b0;
      end else if (s.pos == POS_SEP) begin
        if (c != CH_SPACE) n.match = 1'b0;
      end
    end
    n.pos = (s.pos < POS_MAX) ? s.pos + 3'd1 : POS_MAX;
    return n;
  endfunction

  logic [9:0] code_val;
  assign code_val = 10'(st_r.dig[0]) * 10'd100 + 10'(st_r.dig[1]) * 10'd10
                  + 10'(st_r.dig[2]);

  always_comb begin
    frm_state_t s;
    logic       long_enough;
    s = st_r;
    long_enough = (st_r.pos >= POS_MAX);
    res.emit = 1'b0;
    res.code = code_val;
    res.status = STATUS_OK;
    if (s.cnt != LEN_MAX) s.cnt = s.cnt + 16'd1;
    res.length = s.cnt;
    st_nxt = s;
    if (s.pcr && byte_in == CH_LF) begin
      // end of line
      if (!s.cont) begin
        if (long_enough && s.match && s.sep == SEP_SPACE) begin
          res.emit = 1'b1;
          st_nxt = STATE_RESET;
        end else if (long_enough && s.match && s.sep == SEP_HYPHEN) begin
          st_nxt.cont = 1'b1;
          st_nxt.pos = 3'd0;
          st_nxt.match = 1'b1;
          st_nxt.pcr = 1'b0;
        end else begin
          res.emit = 1'b1;
          res.code = '0;
          res.status = STATUS_MALFORMED;
          st_nxt = STATE_RESET;
        end
      end else if (long_enough && s.match) begin
        res.emit = 1'b1;
        st_nxt = STATE_RESET;
      end else begin
        // skip non-matching continuation line
        st_nxt.pos = 3'd0;
        st_nxt.match = 1'b1;
        st_nxt.pcr = 1'b0;
      end
    end else begin
      if (s.pcr) begin
        // lone CR counts as a line byte
        s.pcr = 1'b0;
        s = take_char(s, CH_CR);
      end
      if (byte_in == CH_CR) s.pcr = 1'b1;
      else s = take_char(s, byte_in);
      st_nxt = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: sv/ftp_reply_framer_unit.sv
`timescale 1ns / 1ps

// FTP control reply framer.
// in_ch carries one received control-channel byte per beat (valid/ready).
// out_ch carries one beat per finished reply: the three-digit code, a status
// (0 complete, 1 malformed first line, code then 0) and the reply length in
// bytes including the final CR LF, saturating at 65535.
// A byte is registered on acceptance and then runs through the framing logic;
// the LF that ends a reply puts its beat in the result register for out_ch.
// One byte per cycle is sustained unless a reply beat waits for out_ch: the
// framing state is updated by combinational logic between the two registers.
// When out_ch stalls with a result held, the input register keeps taking
// bytes until a byte that ends another reply has to wait for the slot; then
// in_ch.ready drops until the held beat is taken.
// Synchronous reset (rst_n low) empties both registers and returns the
// framer to waiting for the first line of a reply.

module ftp_reply_framer_unit
  import ftprf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  ftprf_in_if.sink        in_ch,
  ftprf_out_if.source     out_ch
);

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        out_vld_r;
  logic [9:0]  out_code_r;
  logic        out_status_r;
  logic [15:0] out_len_r;

  frm_result_t res;
  logic        slot_free;
  logic        advance;

  assign slot_free = !out_vld_r || out_ch.ready;
  assign advance = in_vld_r && (!res.emit || slot_free);
  assign in_ch.ready = !in_vld_r || advance;

  ftprf_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_in (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_code_r   <= res.code;
      out_status_r <= res.status;
      out_len_r    <= res.length;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.reply_code   = out_code_r;
  assign out_ch.reply_status = out_status_r;
  assign out_ch.reply_length = out_len_r;

  a_malformed_code_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r == STATUS_MALFORMED |-> out_code_r == 10'd0)
    else $error("malformed reply carries a nonzero code");

  a_length_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_len_r != 16'd0)
    else $error("reply length is zero");

  a_code_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_code_r <= 10'd999)
    else $error("reply code out of range");

  a_held_byte : assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_byte_r))
    else $error("stalled byte lost or changed");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |-> !(advance && res.emit))
    else $error("pending reply overwritten");

endmodule
